/* hw/rtl/hcla_pkg.sv */
// ----------------------------------------------------------------------------
// hcla_pkg
// Shared constants, types and the FNV-1a fold function of the hash-chained
// log appender.
// ----------------------------------------------------------------------------
package hcla_pkg;

    localparam int CHAIN_CAPACITY = 256;
    localparam int PAYLOAD_BYTES  = 96;

    localparam int CNT_W   = $clog2(CHAIN_CAPACITY + 1);
    localparam int TAKEN_W = $clog2(PAYLOAD_BYTES);
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int TS_STEPS = 8;
    localparam int TS_IDX_W = $clog2(TS_STEPS);

    localparam logic [31:0] FNV_PRIME    = 32'd16777619;
    localparam logic [31:0] SEQ_MULT     = 32'd2654435761;
    localparam logic [31:0] GENESIS_LINK = 32'h0000_1505;

    localparam logic [CNT_W-1:0]   CAP_CNT   = CNT_W'(CHAIN_CAPACITY);
    localparam logic [TAKEN_W-1:0] TAKEN_MAX = TAKEN_W'(PAYLOAD_BYTES - 1);

    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic ST_APPENDED = 1'b0;
    localparam logic ST_FULL     = 1'b1;

    typedef struct packed {
        logic        clr;
        logic [31:0] digest;
        logic [63:0] ts;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic        status;
        logic [7:0]  seq;
        logic [31:0] digest;
        logic [31:0] prev;
        logic [31:0] link;
        logic [8:0]  held;
    } t_result;

    function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

/* hw/rtl/hcla_queue.sv */
// ----------------------------------------------------------------------------
// hcla_queue
// Two-entry job queue between the byte front end and the chain back end.
// ----------------------------------------------------------------------------
module hcla_queue
    import hcla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_push_job,
    input  logic    i_pop,
    output t_job    o_head_job,
    output t_q_stat o_stat
);

    t_job             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_AW:0]    r_cnt;
    logic [Q_AW:0]    n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    assign o_head_job   = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

/* hw/rtl/hcla_front.sv */
// ----------------------------------------------------------------------------
// hcla_front
// Accepts input words, folds payload bytes into the running digest and
// queues a job on each last byte or clear.
// ----------------------------------------------------------------------------
module hcla_front
    import hcla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [63:0] i_timestamp_ms,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_job        o_push_job
);

    logic [31:0]        r_digest;
    logic [31:0]        n_digest;
    logic [TAKEN_W-1:0] r_taken;
    logic [TAKEN_W-1:0] n_taken;
    logic               r_ended;
    logic               n_ended;
    logic               accept;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_digest = r_digest;
        n_taken  = r_taken;
        n_ended  = r_ended;
        o_push   = 1'b0;
        o_push_job.clr    = (i_func == FUNC_CLEAR);
        o_push_job.ts     = i_timestamp_ms;
        o_push_job.digest = r_digest;
        if (accept) begin
            if (i_func == FUNC_CLEAR) begin
                o_push   = 1'b1;
                n_digest = GENESIS_LINK;
                n_taken  = '0;
                n_ended  = 1'b0;
            end else begin
                if (!r_ended) begin
                    if (i_data_byte == 8'd0) begin
                        n_ended = 1'b1;
                    end else if (r_taken < TAKEN_MAX) begin
                        n_digest = fnv_fold(r_digest, i_data_byte);
                        n_taken  = r_taken + 1'b1;
                    end
                end
                o_push_job.digest = n_digest;
                if (i_last_byte) begin
                    o_push   = 1'b1;
                    n_digest = GENESIS_LINK;
                    n_taken  = '0;
                    n_ended  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digest <= GENESIS_LINK;
            r_taken  <= '0;
            r_ended  <= 1'b0;
        end else begin
            r_digest <= n_digest;
            r_taken  <= n_taken;
            r_ended  <= n_ended;
        end
    end

endmodule

/* hw/rtl/hcla_back.sv */
// ----------------------------------------------------------------------------
// hcla_back
// Holds the chain head and count, mixes each queued record into the chain
// over the timestamp bytes while the chain has room, and drives the result register.
// ----------------------------------------------------------------------------
module hcla_back
    import hcla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_head_job,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MIX  = 3'b010,
        S_FOLD = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [31:0]         r_head;
    logic [CNT_W-1:0]    r_count;
    logic [31:0]         r_prod;
    logic [31:0]         r_digest;
    logic [63:0]         r_ts;
    logic [31:0]         r_h;
    logic [TS_IDX_W-1:0] r_idx;
    logic                r_out_valid;
    t_result             r_out;
    logic [31:0]         mix;
    logic [31:0]         fold_h;
    logic [CNT_W-1:0]    count_inc;

    assign mix       = r_head ^ r_prod ^ r_digest;
    assign fold_h    = fnv_fold(r_h, r_ts[7:0]);
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_head_job.clr) begin
                        o_pop = 1'b1;
                    end else if (!r_out_valid) begin
                        o_pop = 1'b1;
                        if (r_count < CAP_CNT) begin
                            n_state = S_MIX;
                        end
                    end
                end
            end
            S_MIX: begin
                n_state = S_FOLD;
            end
            S_FOLD: begin
                if (r_idx == TS_IDX_W'(TS_STEPS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= GENESIS_LINK;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_head_job.clr) begin
                        r_head  <= GENESIS_LINK;
                        r_count <= '0;
                    end else if (o_pop && (r_count >= CAP_CNT)) begin
                        r_out_valid <= 1'b1;
                    end
                end
                S_FOLD: begin
                    if (r_idx == TS_IDX_W'(TS_STEPS - 1)) begin
                        r_head      <= fold_h;
                        r_count     <= count_inc;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_prod   <= 32'(32'(r_count) * SEQ_MULT);
                r_digest <= i_head_job.digest;
                r_ts     <= i_head_job.ts;
                if (o_pop && !i_head_job.clr && (r_count >= CAP_CNT)) begin
                    r_out.status <= ST_FULL;
                    r_out.seq    <= 8'd0;
                    r_out.digest <= 32'd0;
                    r_out.prev   <= r_head;
                    r_out.link   <= r_head;
                    r_out.held   <= 9'(r_count);
                end
            end
            S_MIX: begin
                r_h   <= (mix != 32'd0) ? mix : GENESIS_LINK;
                r_idx <= '0;
            end
            S_FOLD: begin
                r_h   <= fold_h;
                r_ts  <= r_ts >> 8;
                r_idx <= r_idx + 1'b1;
                if (r_idx == TS_IDX_W'(TS_STEPS - 1)) begin
                    r_out.status <= ST_APPENDED;
                    r_out.seq    <= 8'(r_count);
                    r_out.digest <= r_digest;
                    r_out.prev   <= r_head;
                    r_out.link   <= fold_h;
                    r_out.held   <= 9'(count_inc);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("record count above capacity");

    a_busy_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("record in flight while result pending");

    a_fold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD && r_idx == TS_IDX_W'(TS_STEPS - 1)) |=> r_out_valid)
        else $error("finished record produced no result");

    a_full_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FULL) |-> (r_out.link == r_out.prev))
        else $error("full result changed the link");
`endif

endmodule

/* hw/rtl/hash_chained_log_appender_unit.sv */
// ----------------------------------------------------------------------------
// hash_chained_log_appender_unit
// FNV-1a hash chain appender: byte front end, job queue and chain back end.
// ----------------------------------------------------------------------------
// Payload bytes are taken one per cycle while the input is not stalled. A
// last byte or a clear word is queued; the back end then pops it in its idle
// state, forms the mix and folds the eight timestamp bytes through its single
// FNV multiplier before the record's result becomes valid. A chain full
// result or a clear is handled in the idle state alone. The back end starts no
// record while a result word waits at the output, and the input stalls only
// while the two-entry queue is full.
module hash_chained_log_appender_unit
    import hcla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [63:0] i_timestamp_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [7:0]  o_sequence_res,
    output logic [31:0] o_payload_digest,
    output logic [31:0] o_previous_link,
    output logic [31:0] o_link_hash,
    output logic [8:0]  o_records_held
);

    t_q_stat q_stat;
    logic    q_push;
    t_job    q_push_job;
    logic    q_pop;
    t_job    q_head_job;
    t_result result;

    hcla_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_timestamp_ms (i_timestamp_ms),
        .i_q_stat       (q_stat),
        .o_push         (q_push),
        .o_push_job     (q_push_job)
    );

    hcla_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_job (q_push_job),
        .i_pop      (q_pop),
        .o_head_job (q_head_job),
        .o_stat     (q_stat)
    );

    hcla_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_job (q_head_job),
        .i_q_stat   (q_stat),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (result)
    );

    assign o_status         = result.status;
    assign o_sequence_res   = result.seq;
    assign o_payload_digest = result.digest;
    assign o_previous_link  = result.prev;
    assign o_link_hash      = result.link;
    assign o_records_held   = result.held;

endmodule
